// ----- src/hcsp_pkg.sv -----
// ----------------------------------------------------------------------------
// hcsp_pkg: shared types and constants of the semaphore pool
// Command and result beat types, command codes, decoded operations and the
// states of the execution sequencer.
// ----------------------------------------------------------------------------
package hcsp_pkg;

	localparam int INDEX_BITS = 6;
	localparam int GEN_BITS = 25;
	localparam logic [GEN_BITS-1:0] GEN_MAX = 25'h1ffffff;

	localparam int SLOTS_DEF = 64;
	localparam int QUEUE_DEPTH_DEF = 8;
	localparam int TASK_ID_BITS_DEF = 8;
	localparam int COUNT_BITS_DEF = 16;

	localparam logic [2:0] CMD_ALLOC = 3'd0;
	localparam logic [2:0] CMD_WAIT = 3'd1;
	localparam logic [2:0] CMD_TRYWAIT = 3'd2;
	localparam logic [2:0] CMD_POST = 3'd3;
	localparam logic [2:0] CMD_FREE = 3'd4;
	localparam logic [2:0] CMD_DETACH = 3'd5;

	typedef struct packed {
		logic [2:0] command;
		logic [30:0] handle;
		logic [15:0] initial_count;
		logic [7:0] task_id;
	} cmd_t;

	typedef struct packed {
		logic ok;
		logic blocked;
		logic [30:0] new_handle;
		logic woken_valid;
		logic [7:0] woken_task;
	} rsp_t;

	typedef enum logic [2:0] {
		OP_ALLOC,
		OP_WAIT,
		OP_TRYWAIT,
		OP_POST,
		OP_FREE,
		OP_DETACH,
		OP_NONE
	} op_t;

	// classified command as it waits in the queue
	typedef struct packed {
		op_t op;
		logic bad;
		logic [INDEX_BITS-1:0] idx;
		logic [GEN_BITS-1:0] gen;
		logic [15:0] init;
		logic [7:0] tid;
	} req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_WAKE,
		S_DSCAN,
		S_DHDR,
		S_DWALK
	} state_t;

endpackage

// ----- src/hcsp_front.sv -----
// ----------------------------------------------------------------------------
// hcsp_front: command intake
// Accepts command beats, decodes the opcode and splits and pre-checks the
// handle before the command enters the queue.
// ----------------------------------------------------------------------------
module hcsp_front #(
	parameter int SLOTS = hcsp_pkg::SLOTS_DEF
) (
	input logic start,
	input logic full,
	input hcsp_pkg::cmd_t cmd,
	output logic push,
	output hcsp_pkg::req_t req
);

	assign push = start && !full;

	always_comb begin
		req.idx = cmd.handle[hcsp_pkg::INDEX_BITS-1:0];
		req.gen = cmd.handle[30:hcsp_pkg::INDEX_BITS];
		req.init = cmd.initial_count;
		req.tid = cmd.task_id;
		// index beyond the pool or generation zero never names a live slot
		req.bad = ({1'b0, req.idx} >= 7'(SLOTS)) || (req.gen == '0);
		unique case (cmd.command)
			hcsp_pkg::CMD_ALLOC: req.op = hcsp_pkg::OP_ALLOC;
			hcsp_pkg::CMD_WAIT: req.op = hcsp_pkg::OP_WAIT;
			hcsp_pkg::CMD_TRYWAIT: req.op = hcsp_pkg::OP_TRYWAIT;
			hcsp_pkg::CMD_POST: req.op = hcsp_pkg::OP_POST;
			hcsp_pkg::CMD_FREE: req.op = hcsp_pkg::OP_FREE;
			hcsp_pkg::CMD_DETACH: req.op = hcsp_pkg::OP_DETACH;
			default: req.op = hcsp_pkg::OP_NONE;
		endcase
	end

endmodule

// ----- src/hcsp_queue.sv -----
// ----------------------------------------------------------------------------
// hcsp_queue: two-entry command queue
// Decouples command intake from execution.
// ----------------------------------------------------------------------------
module hcsp_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input hcsp_pkg::req_t wdata,
	input logic pop,
	output hcsp_pkg::req_t rdata,
	output logic full,
	output logic empty
);

	hcsp_pkg::req_t ent_q [2];
	logic wp_q;
	logic rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n) empty |-> !pop)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");

endmodule

// ----- src/hcsp_back.sv -----
// ----------------------------------------------------------------------------
// hcsp_back: command execution
// Sequencer over the slot table and waiter memory: handle checks, count
// updates, queue push and pop, and the detach sweep.
// ----------------------------------------------------------------------------
module hcsp_back #(
	parameter int SLOTS = hcsp_pkg::SLOTS_DEF,
	parameter int QUEUE_DEPTH = hcsp_pkg::QUEUE_DEPTH_DEF,
	parameter int TASK_ID_BITS = hcsp_pkg::TASK_ID_BITS_DEF,
	parameter int COUNT_BITS = hcsp_pkg::COUNT_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input hcsp_pkg::req_t rq,
	output logic pop,
	output logic done,
	output hcsp_pkg::rsp_t rsp
);

	localparam int IW = $clog2(SLOTS);
	localparam int QB = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int LB = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = $clog2(SLOTS * QUEUE_DEPTH);
	localparam int GB = hcsp_pkg::GEN_BITS;
	localparam int IB = hcsp_pkg::INDEX_BITS;
	localparam logic [32:0] CMAX = (33'd1 << COUNT_BITS) - 33'd1;

	function automatic logic [AW-1:0] qpos(logic [IW-1:0] s, logic [QB-1:0] h,
		logic [LB-1:0] k);
		logic [LB:0] p;
		p = (LB+1)'(h) + (LB+1)'(k);
		if (p >= (LB+1)'(QUEUE_DEPTH)) begin
			p = p - (LB+1)'(QUEUE_DEPTH);
		end
		return AW'(s) * AW'(QUEUE_DEPTH) + AW'(p);
	endfunction

	// slot table memories
	logic [GB-1:0] gen_mem [SLOTS];
	logic [COUNT_BITS-1:0] cnt_mem [SLOTS];
	logic [QB-1:0] head_mem [SLOTS];
	logic [LB-1:0] len_mem [SLOTS];
	logic [TASK_ID_BITS-1:0] wait_mem [SLOTS*QUEUE_DEPTH];

	logic s_re, s_we;
	logic [IW-1:0] s_ra, s_wa;
	logic [GB-1:0] s_wgen;
	logic [COUNT_BITS-1:0] s_wcnt;
	logic [QB-1:0] s_whead;
	logic [LB-1:0] s_wlen;
	logic w_re, w_we;
	logic [AW-1:0] w_ra, w_wa;
	logic [TASK_ID_BITS-1:0] w_wd;

	logic [GB-1:0] gen_rd_q;
	logic gvld_rd_q;
	logic [COUNT_BITS-1:0] cnt_rd_q;
	logic [QB-1:0] head_rd_q;
	logic [LB-1:0] len_rd_q;
	logic [TASK_ID_BITS-1:0] w_rd_q;

	hcsp_pkg::state_t state_q, state_d;
	hcsp_pkg::req_t req_q;
	logic [IW-1:0] slot_q, slot_d;
	logic [LB-1:0] k_q, k_d, n_q, n_d;
	logic pend_q, pend_d;
	logic [SLOTS-1:0] in_use_q, in_use_d, gvld_q, gvld_d;
	hcsp_pkg::rsp_t res_q, res_d;
	logic res_vld_q, res_we;

	logic [IW-1:0] rq_idx, free_idx;
	logic free_any;
	logic [GB-1:0] r_gen, g_next;
	logic gen_hit, last, walk_done, rq_live;
	logic [15:0] tid_ext, wrd_ext;
	logic [TASK_ID_BITS-1:0] tid;
	logic [32:0] init_ext;
	logic [COUNT_BITS-1:0] init_sat;

	assign rq_idx = rq.idx[IW-1:0];
	assign rq_live = !rq.bad && in_use_q[rq_idx];
	assign r_gen = gvld_rd_q ? gen_rd_q : '0;
	assign gen_hit = (r_gen == req_q.gen);
	assign g_next = (r_gen == hcsp_pkg::GEN_MAX) ? GB'(1) : r_gen + GB'(1);
	assign last = (slot_q == IW'(SLOTS - 1));
	assign walk_done = (k_q == len_rd_q) && !pend_q;
	assign tid_ext = 16'(req_q.tid);
	assign tid = tid_ext[TASK_ID_BITS-1:0];
	assign wrd_ext = 16'(w_rd_q);
	assign init_ext = 33'(req_q.init);
	assign init_sat = (init_ext > CMAX) ? CMAX[COUNT_BITS-1:0] : init_ext[COUNT_BITS-1:0];
	assign pop = (state_q == hcsp_pkg::S_IDLE) && !empty;
	assign done = res_vld_q;
	assign rsp = res_q;

	// lowest free slot
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_any = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hcsp_pkg::S_IDLE: begin
				if (!empty) begin
					case (rq.op) inside
						hcsp_pkg::OP_ALLOC: if (free_any) state_d = hcsp_pkg::S_LOOK;
						hcsp_pkg::OP_WAIT, hcsp_pkg::OP_TRYWAIT, hcsp_pkg::OP_POST,
						hcsp_pkg::OP_FREE: if (rq_live) state_d = hcsp_pkg::S_LOOK;
						hcsp_pkg::OP_DETACH: state_d = hcsp_pkg::S_DSCAN;
						default: state_d = hcsp_pkg::S_IDLE;
					endcase
				end
			end
			hcsp_pkg::S_LOOK: begin
				if (req_q.op == hcsp_pkg::OP_POST && gen_hit && len_rd_q != '0) begin
					state_d = hcsp_pkg::S_WAKE;
				end else begin
					state_d = hcsp_pkg::S_IDLE;
				end
			end
			hcsp_pkg::S_WAKE: state_d = hcsp_pkg::S_IDLE;
			hcsp_pkg::S_DSCAN: begin
				if (in_use_q[slot_q]) begin
					state_d = hcsp_pkg::S_DHDR;
				end else if (last) begin
					state_d = hcsp_pkg::S_IDLE;
				end
			end
			hcsp_pkg::S_DHDR: state_d = hcsp_pkg::S_DWALK;
			hcsp_pkg::S_DWALK: begin
				if (walk_done) begin
					state_d = last ? hcsp_pkg::S_IDLE : hcsp_pkg::S_DSCAN;
				end
			end
			default: state_d = hcsp_pkg::S_IDLE;
		endcase
	end

	// datapath and memory control
	always_comb begin
		s_re = 1'b0; s_ra = slot_q;
		s_we = 1'b0; s_wa = slot_q;
		s_wgen = r_gen; s_wcnt = cnt_rd_q; s_whead = head_rd_q; s_wlen = len_rd_q;
		w_re = 1'b0; w_ra = '0;
		w_we = 1'b0; w_wa = '0; w_wd = tid;
		slot_d = slot_q; k_d = k_q; n_d = n_q; pend_d = pend_q;
		in_use_d = in_use_q; gvld_d = gvld_q;
		res_d = '0; res_we = 1'b0;
		unique case (state_q)
			hcsp_pkg::S_IDLE: begin
				if (!empty) begin
					case (rq.op) inside
						hcsp_pkg::OP_ALLOC: begin
							if (free_any) begin
								slot_d = free_idx; s_re = 1'b1; s_ra = free_idx;
							end else begin
								res_we = 1'b1;
							end
						end
						hcsp_pkg::OP_WAIT, hcsp_pkg::OP_TRYWAIT, hcsp_pkg::OP_POST,
						hcsp_pkg::OP_FREE: begin
							if (rq_live) begin
								slot_d = rq_idx; s_re = 1'b1; s_ra = rq_idx;
							end else begin
								res_we = 1'b1;
							end
						end
						hcsp_pkg::OP_DETACH: slot_d = '0;
						default: res_we = 1'b1;
					endcase
				end
			end
			hcsp_pkg::S_LOOK: begin
				res_we = 1'b1;
				if (req_q.op == hcsp_pkg::OP_ALLOC) begin
					s_we = 1'b1; s_wgen = g_next; s_wcnt = init_sat;
					s_whead = '0; s_wlen = '0;
					in_use_d[slot_q] = 1'b1;
					gvld_d[slot_q] = 1'b1;
					res_d.ok = 1'b1;
					res_d.new_handle = {g_next, IB'(slot_q)};
				end else if (gen_hit) begin
					case (req_q.op) inside
						hcsp_pkg::OP_WAIT, hcsp_pkg::OP_TRYWAIT: begin
							if (cnt_rd_q != '0) begin
								s_we = 1'b1; s_wcnt = cnt_rd_q - COUNT_BITS'(1);
								res_d.ok = 1'b1;
							end else if (req_q.op == hcsp_pkg::OP_WAIT &&
								len_rd_q < LB'(QUEUE_DEPTH)) begin
								w_we = 1'b1; w_wa = qpos(slot_q, head_rd_q, len_rd_q);
								s_we = 1'b1; s_wlen = len_rd_q + LB'(1);
								res_d.ok = 1'b1; res_d.blocked = 1'b1;
							end
						end
						hcsp_pkg::OP_POST: begin
							if (len_rd_q != '0) begin
								// wake the oldest waiter once its id is read
								res_we = 1'b0;
								w_re = 1'b1; w_ra = qpos(slot_q, head_rd_q, '0);
								s_we = 1'b1; s_wlen = len_rd_q - LB'(1);
								s_whead = (head_rd_q == QB'(QUEUE_DEPTH - 1)) ? '0 :
									head_rd_q + QB'(1);
							end else begin
								if (cnt_rd_q != CMAX[COUNT_BITS-1:0]) begin
									s_we = 1'b1; s_wcnt = cnt_rd_q + COUNT_BITS'(1);
								end
								res_d.ok = 1'b1;
							end
						end
						hcsp_pkg::OP_FREE: begin
							if (len_rd_q == '0) begin
								in_use_d[slot_q] = 1'b0;
								res_d.ok = 1'b1;
							end
						end
						default: res_d.ok = 1'b0;
					endcase
				end
			end
			hcsp_pkg::S_WAKE: begin
				res_we = 1'b1;
				res_d.ok = 1'b1;
				res_d.woken_valid = 1'b1;
				res_d.woken_task = wrd_ext[7:0];
			end
			hcsp_pkg::S_DSCAN: begin
				if (in_use_q[slot_q]) begin
					s_re = 1'b1;
				end else if (last) begin
					res_we = 1'b1; res_d.ok = 1'b1;
				end else begin
					slot_d = slot_q + IW'(1);
				end
			end
			hcsp_pkg::S_DHDR: begin
				k_d = '0; n_d = '0; pend_d = 1'b0;
			end
			hcsp_pkg::S_DWALK: begin
				// compact in place: keep entries that do not match the task
				if (pend_q && w_rd_q != tid) begin
					w_we = 1'b1; w_wa = qpos(slot_q, head_rd_q, n_q); w_wd = w_rd_q;
					n_d = n_q + LB'(1);
				end
				if (k_q != len_rd_q) begin
					w_re = 1'b1; w_ra = qpos(slot_q, head_rd_q, k_q);
					k_d = k_q + LB'(1);
					pend_d = 1'b1;
				end else begin
					pend_d = 1'b0;
				end
				if (walk_done) begin
					s_we = 1'b1; s_wlen = n_q;
					if (last) begin
						res_we = 1'b1; res_d.ok = 1'b1;
					end else begin
						slot_d = slot_q + IW'(1);
					end
				end
			end
			default: res_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_we) begin
			gen_mem[s_wa] <= s_wgen;
			cnt_mem[s_wa] <= s_wcnt;
			head_mem[s_wa] <= s_whead;
			len_mem[s_wa] <= s_wlen;
		end
		if (s_re) begin
			gen_rd_q <= gen_mem[s_ra];
			gvld_rd_q <= gvld_q[s_ra];
			cnt_rd_q <= cnt_mem[s_ra];
			head_rd_q <= head_mem[s_ra];
			len_rd_q <= len_mem[s_ra];
		end
		if (w_we) begin
			wait_mem[w_wa] <= w_wd;
		end
		if (w_re) begin
			w_rd_q <= wait_mem[w_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			req_q <= rq;
		end
		slot_q <= slot_d;
		k_q <= k_d;
		n_q <= n_d;
		res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hcsp_pkg::S_IDLE;
			in_use_q <= '0;
			gvld_q <= '0;
			pend_q <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			in_use_q <= in_use_d;
			gvld_q <= gvld_d;
			pend_q <= pend_d;
			res_vld_q <= res_we;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q != hcsp_pkg::S_IDLE) || res_vld_q)
		else $error("popped command neither executing nor answered");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hcsp_pkg::S_WAKE |=> res_vld_q && res_q.woken_valid)
		else $error("wake without woken result");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hcsp_pkg::S_DWALK |-> n_q <= k_q)
		else $error("detach compaction overtook its read pointer");
	assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q |=> !res_vld_q || $past(state_q == hcsp_pkg::S_IDLE))
		else $error("back-to-back results outside idle");

endmodule

// ----- src/handle_checked_semaphore_pool_unit.sv -----
// ----------------------------------------------------------------------------
// handle_checked_semaphore_pool_unit: pool of counting semaphores with
// generation-checked handles
// Top level: command intake, two-entry command queue and execution sequencer.
// ----------------------------------------------------------------------------
// Issue a command beat on req with start high while busy is low. Each command
// yields exactly one result beat on rsp, marked by done for one cycle; the
// receiver cannot stall, so sample rsp whenever done is high. Commands run one
// at a time in the execution sequencer, which owns a single-port slot table
// and the waiter memory. A handle command or an alloc reads its slot record
// and is answered from the look state; a post that wakes a waiter adds a
// wake state that reads the waiter's id. A rejected command or a full pool
// is answered from idle. Detach sweeps every slot: a free slot is skipped,
// a slot in use has its header read and its waiting list compacted in place,
// and the result follows the last slot. The two-entry queue takes commands
// while the sequencer works; busy rises only when both entries hold commands.
module handle_checked_semaphore_pool_unit #(
	parameter int SLOTS = hcsp_pkg::SLOTS_DEF,
	parameter int QUEUE_DEPTH = hcsp_pkg::QUEUE_DEPTH_DEF,
	parameter int TASK_ID_BITS = hcsp_pkg::TASK_ID_BITS_DEF,
	parameter int COUNT_BITS = hcsp_pkg::COUNT_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input hcsp_pkg::cmd_t req,
	output logic done,
	output hcsp_pkg::rsp_t rsp
);

	logic push, pop, full, empty;
	hcsp_pkg::req_t push_req, head_req;

	// hold off new beats only when the queue is full
	assign busy = full;

	hcsp_front #(
		.SLOTS(SLOTS)
	) u_front (
		.start(start),
		.full(full),
		.cmd(req),
		.push(push),
		.req(push_req)
	);

	hcsp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(push_req),
		.pop(pop),
		.rdata(head_req),
		.full(full),
		.empty(empty)
	);

	hcsp_back #(
		.SLOTS(SLOTS),
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.TASK_ID_BITS(TASK_ID_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(empty),
		.rq(head_req),
		.pop(pop),
		.done(done),
		.rsp(rsp)
	);

endmodule
